@@ src/sil_pkg.sv @@
// Shared types and constants of the sorted index link table.
package sil_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int CFG_W           = 11;
    localparam int ACTION_W        = 3;
    localparam int INDEX_W         = 10;
    localparam int STATUS_W        = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_NEXT   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PREV   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FILL   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_RANGE   = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [INDEX_W-1:0]   link;
    } t_result;

endpackage

@@ src/sil_link_mem.sv @@
// Next and prev link memories: one shared read port, one write port each.
module sil_link_mem #(
    parameter int DEPTH = sil_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output logic [AW-1:0] o_rd_next,
    output logic [AW-1:0] o_rd_prev,
    input  logic          i_nx_we,
    input  logic [AW-1:0] i_nx_addr,
    input  logic [AW-1:0] i_nx_data,
    input  logic          i_pv_we,
    input  logic [AW-1:0] i_pv_addr,
    input  logic [AW-1:0] i_pv_data
);

    logic [AW-1:0] r_next_mem [DEPTH];
    logic [AW-1:0] r_prev_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_nx_we) begin
            r_next_mem[i_nx_addr] <= i_nx_data;
        end
        o_rd_next <= r_next_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_pv_we) begin
            r_prev_mem[i_pv_addr] <= i_pv_data;
        end
        o_rd_prev <= r_prev_mem[i_rd_addr];
    end

endmodule

@@ src/sil_seq.sv @@
// Sequencer: sweeps, lookups, predecessor scan and link splicing.
module sil_seq #(
    parameter int TABLE_DEPTH = sil_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  logic [sil_pkg::ACTION_W-1:0]  i_action,
    input  logic [sil_pkg::INDEX_W-1:0]   i_index,
    input  logic [sil_pkg::CFG_W-1:0]     i_eff_size,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output sil_pkg::t_result              o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ((AW > sil_pkg::CFG_W) ? AW : sil_pkg::CFG_W) + 1;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    typedef enum logic [7:0] {
        S_SWEEP = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_EVAL  = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_LINK  = 8'b0010_0000,
        S_DROP  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                         r_state, n_state;
    logic [sil_pkg::ACTION_W-1:0]   r_action, n_action;
    logic [AW-1:0]                  r_idx, n_idx;
    logic [AW-1:0]                  r_sweep, n_sweep;
    logic                           r_fill, n_fill;
    logic                           r_item, n_item;
    logic [AW-1:0]                  r_scan, n_scan;
    logic [AW-1:0]                  r_cand, n_cand;
    logic                           r_dv, n_dv;
    logic [AW-1:0]                  r_head_next, n_head_next;
    sil_pkg::t_result               r_res, n_res;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_next;
    logic [AW-1:0] rd_prev;
    logic          nx_we;
    logic [AW-1:0] nx_addr;
    logic [AW-1:0] nx_data;
    logic          pv_we;
    logic [AW-1:0] pv_addr;
    logic [AW-1:0] pv_data;

    logic          in_range;
    logic          idx_linked;
    logic          cand_linked;
    logic [CW-1:0] size_x;
    logic [CW-1:0] sweep_x;
    logic [AW-1:0] fill_next;
    logic [AW-1:0] fill_prev;

    sil_link_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_next (rd_next),
        .o_rd_prev (rd_prev),
        .i_nx_we   (nx_we),
        .i_nx_addr (nx_addr),
        .i_nx_data (nx_data),
        .i_pv_we   (pv_we),
        .i_pv_addr (pv_addr),
        .i_pv_data (pv_data)
    );

    assign in_range    = {1'b0, i_index} < i_eff_size;
    assign idx_linked  = (r_idx == '0) || (rd_next != '0) || (rd_prev != '0)
                         || (r_head_next == r_idx);
    assign cand_linked = (r_cand == '0) || (rd_next != '0) || (rd_prev != '0)
                         || (r_head_next == r_cand);

    assign size_x  = CW'(i_eff_size);
    assign sweep_x = CW'(r_sweep);

    always_comb begin
        fill_next = '0;
        fill_prev = '0;
        if (r_fill && (sweep_x < size_x)) begin
            if ((sweep_x + CW'(1)) < size_x) begin
                fill_next = AW'(sweep_x + CW'(1));
            end
            if (r_sweep == '0) begin
                fill_prev = AW'(size_x - CW'(1));
            end else begin
                fill_prev = r_sweep - AW'(1);
            end
        end
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_idx       = r_idx;
        n_sweep     = r_sweep;
        n_fill      = r_fill;
        n_item      = r_item;
        n_scan      = r_scan;
        n_cand      = r_cand;
        n_dv        = r_dv;
        n_res       = r_res;
        rd_addr     = r_idx;
        nx_we       = 1'b0;
        nx_addr     = r_idx;
        nx_data     = '0;
        pv_we       = 1'b0;
        pv_addr     = r_idx;
        pv_data     = '0;

        case (r_state)
            S_SWEEP: begin
                nx_we   = 1'b1;
                nx_addr = r_sweep;
                nx_data = fill_next;
                pv_we   = 1'b1;
                pv_addr = r_sweep;
                pv_data = fill_prev;
                n_sweep = r_sweep + AW'(1);
                if (r_sweep == LAST) begin
                    n_state = r_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    n_action   = i_action;
                    n_idx      = AW'(i_index);
                    n_res.link = '0;
                    n_res.status = sil_pkg::ST_DONE;
                    n_sweep    = '0;
                    n_item     = 1'b1;
                    case (i_action)
                        sil_pkg::ACT_INSERT, sil_pkg::ACT_REMOVE: begin
                            if (!in_range || (i_index == '0)) begin
                                n_res.status = sil_pkg::ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        sil_pkg::ACT_NEXT, sil_pkg::ACT_PREV: begin
                            if (!in_range) begin
                                n_res.status = sil_pkg::ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        sil_pkg::ACT_FILL: begin
                            n_fill  = 1'b1;
                            n_state = S_SWEEP;
                        end
                        sil_pkg::ACT_CLEAR: begin
                            n_fill  = 1'b0;
                            n_state = S_SWEEP;
                        end
                        default: begin
                            n_res.status = sil_pkg::ST_RANGE;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (r_action)
                    sil_pkg::ACT_NEXT: begin
                        n_res.link = sil_pkg::INDEX_W'(rd_next);
                        n_state    = S_DONE;
                    end
                    sil_pkg::ACT_PREV: begin
                        n_res.link = sil_pkg::INDEX_W'(rd_prev);
                        n_state    = S_DONE;
                    end
                    sil_pkg::ACT_REMOVE: begin
                        if (!idx_linked) begin
                            n_res.status = sil_pkg::ST_REFUSED;
                            n_state      = S_DONE;
                        end else begin
                            nx_we   = 1'b1;
                            nx_addr = rd_prev;
                            nx_data = rd_next;
                            pv_we   = 1'b1;
                            pv_addr = rd_next;
                            pv_data = rd_prev;
                            n_state = S_DROP;
                        end
                    end
                    sil_pkg::ACT_INSERT: begin
                        if (idx_linked) begin
                            n_res.status = sil_pkg::ST_REFUSED;
                            n_state      = S_DONE;
                        end else begin
                            n_scan  = r_idx - AW'(1);
                            n_dv    = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                rd_addr = r_scan;
                if (r_dv && cand_linked) begin
                    nx_we   = 1'b1;
                    nx_addr = r_idx;
                    nx_data = rd_next;
                    pv_we   = 1'b1;
                    pv_addr = rd_next;
                    pv_data = r_idx;
                    n_state = S_LINK;
                end else begin
                    n_cand = r_scan;
                    n_scan = r_scan - AW'(1);
                    n_dv   = 1'b1;
                end
            end
            S_LINK: begin
                nx_we   = 1'b1;
                nx_addr = r_cand;
                nx_data = r_idx;
                pv_we   = 1'b1;
                pv_addr = r_idx;
                pv_data = r_cand;
                n_state = S_DONE;
            end
            S_DROP: begin
                nx_we   = 1'b1;
                nx_addr = r_idx;
                nx_data = '0;
                pv_we   = 1'b1;
                pv_addr = r_idx;
                pv_data = '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head_next = r_head_next;
        if (nx_we && (nx_addr == '0)) begin
            n_head_next = nx_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_fill      <= 1'b0;
            r_item      <= 1'b0;
            r_dv        <= 1'b0;
            r_head_next <= '0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_fill      <= n_fill;
            r_item      <= n_item;
            r_dv        <= n_dv;
            r_head_next <= n_head_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_idx    <= n_idx;
        r_scan   <= n_scan;
        r_cand   <= n_cand;
        r_res    <= n_res;
    end

endmodule

@@ src/sorted_index_link_table.sv @@
// Top level of the sorted index link table: config register, sequencer, result register.
//
//  channel  | valid / ready              | payload
//  ---------+----------------------------+----------------------------------
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_entries_in_use
//  in       | i_in_valid / o_in_ready    | i_action, i_entry_index
//  out      | o_out_valid / i_out_ready  | o_status, o_link_index
//
//  An insert scans down from its entry one entry per cycle through the link
//  memory read port until it reaches its linked predecessor.
//  Fill and clear sweep every entry.
//  After reset a clearing sweep runs before the first transaction.
//  A result waits in the output register; the next transaction is taken meanwhile.
module sorted_index_link_table #(
    parameter int TABLE_DEPTH = sil_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sil_pkg::CFG_W-1:0]     i_cfg_entries_in_use,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sil_pkg::ACTION_W-1:0]  i_action,
    input  logic [sil_pkg::INDEX_W-1:0]   i_entry_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sil_pkg::STATUS_W-1:0]  o_status,
    output logic [sil_pkg::INDEX_W-1:0]   o_link_index
);

    logic [sil_pkg::CFG_W-1:0] r_cfg;
    logic [sil_pkg::CFG_W-1:0] eff_size;
    logic                      r_out_valid, n_out_valid;
    sil_pkg::t_result          r_out;
    logic                      res_valid;
    logic                      res_ready;
    sil_pkg::t_result          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= sil_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_entries_in_use;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            eff_size = sil_pkg::CFG_W'(1);
        end else if (32'(r_cfg) > TABLE_DEPTH) begin
            eff_size = sil_pkg::CFG_W'(TABLE_DEPTH);
        end else begin
            eff_size = r_cfg;
        end
    end

    sil_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in_valid),
        .o_item_ready (o_in_ready),
        .i_action     (i_action),
        .i_index      (i_entry_index),
        .i_eff_size   (eff_size),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_ready) begin
            n_out_valid = res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_link_index = r_out.link;

endmodule

@@ src/sil_checker.sv @@
// Port-level checks of the sorted index link table, bound to the top level.
module sil_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [sil_pkg::STATUS_W-1:0]  o_status,
    input logic [sil_pkg::INDEX_W-1:0]   o_link_index
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == sil_pkg::ST_DONE) || (o_status == sil_pkg::ST_RANGE)
                        || (o_status == sil_pkg::ST_REFUSED))
        else $error("undefined status code");

    a_link_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != sil_pkg::ST_DONE)) |-> (o_link_index == '0))
        else $error("nonzero link on a failed transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_status) && $stable(o_link_index)))
        else $error("stalled result changed");

endmodule

bind sorted_index_link_table sil_checker u_sil_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_link_index (o_link_index)
);
